// ===== hw/rtl/modbus_tcp_read_transaction_engine_defines.svh =====
// Assertion macros shared by the Modbus TCP read transaction engine RTL.
// Every macro expects a clock named clk and a synchronous reset named rst.
`ifndef MODBUS_TCP_READ_TRANSACTION_ENGINE_DEFINES_SVH
`define MODBUS_TCP_READ_TRANSACTION_ENGINE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MBTRE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MBTRE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mbtre_pkg.sv =====
// Shared types, codes and helpers of the Modbus TCP read transaction engine.
// No dependencies; every other RTL file of the block refers to it by scope.
package mbtre_pkg;

  localparam int TAG_BITS = 16;

  // Request item kinds.
  localparam logic [1:0] REQ_READ = 2'd0;
  localparam logic [1:0] REQ_BYTE = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;
  localparam logic [1:0] REQ_LINK = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_TX   = 2'd0;
  localparam logic [1:0] KIND_GOOD = 2'd1;
  localparam logic [1:0] KIND_BAD  = 2'd2;

  // Data types.
  localparam logic [2:0] DT_UINT16  = 3'd0;
  localparam logic [2:0] DT_INT16   = 3'd1;
  localparam logic [2:0] DT_UINT32  = 3'd2;
  localparam logic [2:0] DT_INT32   = 3'd3;
  localparam logic [2:0] DT_FLOAT32 = 3'd4;

  // Failure causes.
  localparam logic [2:0] CAUSE_NONE      = 3'd0;
  localparam logic [2:0] CAUSE_EXCEPTION = 3'd1;
  localparam logic [2:0] CAUSE_SHORT     = 3'd2;
  localparam logic [2:0] CAUSE_TIMEOUT   = 3'd3;
  localparam logic [2:0] CAUSE_LINK      = 3'd4;

  localparam logic [15:0] TIMEOUT_RESET  = 16'd1000;
  localparam logic [3:0]  FRAME_LAST_IDX = 4'd11;
  localparam int          JOBQ_DEPTH     = 4;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [7:0]          rx_byte;
    logic [7:0]          unit_id;
    logic [7:0]          function_code;
    logic [15:0]         reg_address;
    logic [2:0]          data_fmt;
    logic                swap_words;
    logic [TAG_BITS-1:0] tag_id;
  } item_t;

  typedef struct packed {
    logic [1:0]          out_kind;
    logic [7:0]          tx_byte;
    logic                frame_last;
    logic [TAG_BITS-1:0] result_tag;
    logic [31:0]         value_bits;
    logic [2:0]          value_type;
    logic [2:0]          fail_cause;
  } result_t;

  // One unit of work for the back end: a request frame to send, or a single value.
  typedef struct packed {
    logic [1:0]          kind;
    logic [15:0]         tid;
    logic [7:0]          unit_id;
    logic [7:0]          func;
    logic [15:0]         addr;
    logic                qty_two;
    logic [TAG_BITS-1:0] tag;
    logic [31:0]         bits;
    logic [2:0]          vtype;
    logic [2:0]          cause;
  } job_t;

  typedef enum logic {
    BK_IDLE,
    BK_FRAME
  } back_state_t;

  // Byte idx of the 12-byte request frame (MBAP header and read PDU).
  function automatic logic [7:0] frame_byte(job_t j, logic [3:0] idx);
    logic [7:0] b;
    b = 8'd0;
    unique case (idx)
      4'd0:    b = j.tid[15:8];
      4'd1:    b = j.tid[7:0];
      4'd5:    b = 8'd6;
      4'd6:    b = j.unit_id;
      4'd7:    b = j.func;
      4'd8:    b = j.addr[15:8];
      4'd9:    b = j.addr[7:0];
      4'd11:   b = j.qty_two ? 8'd2 : 8'd1;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

// ===== hw/rtl/modbus_tcp_read_transaction_engine.sv =====
// Top level of the Modbus TCP read transaction engine.
// Depends on mbtre_pkg, mbtre_front, mbtre_jobq and mbtre_back.

// This block runs the client side of one Modbus TCP read (function 3 or 4) at a
// time. An item is taken on every cycle in which push is high and full is low;
// each item is handled by the front end, which owns all the transaction state:
// the request counter, the pending read, the tick counter and the byte deframer.
// A valid read request taken while no read is pending turns into a 12-byte MBAP
// frame; a complete reply, timeout or link loss turns into one good or bad
// value, and other items produce nothing. The work goes through a four-entry
// job queue to the back end, which drives the result ports and delivers one
// transfer per cycle while results are popped, so a read request occupies the
// result side while bytes and ticks keep flowing in behind it; full rises only
// when the job queue fills. Results leave in the order their items arrived and
// are taken with pop while empty is low. The timeout register resets to 1000
// ticks and is written with cfg_we; write it only while the block is idle.
module modbus_tcp_read_transaction_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  mbtre_pkg::item_t    item,
  output logic                empty,
  input  logic                pop,
  output mbtre_pkg::result_t  result,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata
);

  logic            accept;
  logic            job_valid;
  mbtre_pkg::job_t job;
  logic            q_full;
  logic            q_empty;
  logic            q_pop;
  mbtre_pkg::job_t q_job;

  // Every accepted item yields at most one job, so gating on a free queue
  // slot is all the back pressure the front end needs.
  assign full   = q_full;
  assign accept = push && !q_full;

  mbtre_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .job_valid (job_valid),
    .job       (job)
  );

  mbtre_jobq u_jobq (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (job_valid),
    .wr_job (job),
    .full   (q_full),
    .rd_en  (q_pop),
    .rd_job (q_job),
    .empty  (q_empty)
  );

  mbtre_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_job   (q_job),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule

// ===== hw/rtl/mbtre_front.sv =====
// Front end: accepts items, tracks the transaction state and deframes replies.
// Depends on mbtre_pkg; emits at most one job per accepted item.
module mbtre_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  mbtre_pkg::item_t   item,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  output logic               job_valid,
  output mbtre_pkg::job_t    job
);

  logic [15:0] timeout;
  logic [15:0] txn_ctr, txn_ctr_next;
  logic        waiting, waiting_next;
  logic [15:0] pend_txn, pend_txn_next;
  logic [mbtre_pkg::TAG_BITS-1:0] pend_tag, pend_tag_next;
  logic [2:0]  pend_type, pend_type_next;
  logic        pend_order, pend_order_next;
  logic [15:0] elapsed, elapsed_next;
  logic [16:0] rx_pos, rx_pos_next;
  logic [7:0]  hdr [9];
  logic [7:0]  hdr_next [9];
  logic [7:0]  regs [4];
  logic [7:0]  regs_next [4];

  logic [15:0] ctr_inc;
  logic [16:0] pos_inc;
  logic [15:0] frame_len;
  logic [15:0] w0, w1;
  logic [7:0]  count;
  logic [7:0]  need;

  always_comb begin
    txn_ctr_next    = txn_ctr;
    waiting_next    = waiting;
    pend_txn_next   = pend_txn;
    pend_tag_next   = pend_tag;
    pend_type_next  = pend_type;
    pend_order_next = pend_order;
    elapsed_next    = elapsed;
    rx_pos_next     = rx_pos;
    hdr_next        = hdr;
    regs_next       = regs;
    job_valid       = 1'b0;
    job             = '0;
    ctr_inc         = txn_ctr + 16'd1;
    pos_inc         = rx_pos + 17'd1;
    frame_len       = 16'd0;
    w0              = 16'd0;
    w1              = 16'd0;
    count           = 8'd0;
    need            = 8'd0;

    if (accept) begin
      unique case (item.req_type)
        mbtre_pkg::REQ_READ: begin
          if (!waiting && item.data_fmt <= mbtre_pkg::DT_FLOAT32) begin
            txn_ctr_next    = (ctr_inc == 16'd0) ? 16'd1 : ctr_inc;
            pend_txn_next   = txn_ctr_next;
            pend_tag_next   = item.tag_id;
            pend_type_next  = item.data_fmt;
            pend_order_next = item.swap_words;
            elapsed_next    = 16'd0;
            waiting_next    = 1'b1;
            job_valid       = 1'b1;
            job.kind        = mbtre_pkg::KIND_TX;
            job.tid         = txn_ctr_next;
            job.unit_id     = item.unit_id;
            job.func        = item.function_code;
            job.addr        = item.reg_address;
            job.qty_two     = (item.data_fmt > mbtre_pkg::DT_INT16);
          end
        end
        mbtre_pkg::REQ_BYTE: begin
          for (int i = 0; i < 9; i++) begin
            if (rx_pos == 17'(i)) hdr_next[i] = item.rx_byte;
          end
          for (int i = 0; i < 4; i++) begin
            if (rx_pos == 17'(i + 9)) regs_next[i] = item.rx_byte;
          end
          rx_pos_next = pos_inc;
          frame_len   = {hdr_next[4], hdr_next[5]};
          count       = hdr_next[8];
          need        = (pend_type <= mbtre_pkg::DT_INT16) ? 8'd2 : 8'd4;
          w0          = {regs_next[0], regs_next[1]};
          w1          = {regs_next[2], regs_next[3]};
          if (pos_inc >= 17'(frame_len) + 17'd6) begin
            rx_pos_next = 17'd0;
            // Short frames, foreign protocols and stale transactions vanish.
            if (pos_inc >= 17'd9 && hdr_next[2] == 8'd0 && hdr_next[3] == 8'd0 &&
                waiting && {hdr_next[0], hdr_next[1]} == pend_txn) begin
              waiting_next = 1'b0;
              job_valid    = 1'b1;
              job.tag      = pend_tag;
              job.vtype    = pend_type;
              if (hdr_next[7][7]) begin
                job.kind  = mbtre_pkg::KIND_BAD;
                job.cause = mbtre_pkg::CAUSE_EXCEPTION;
              end else if (pos_inc < 17'd9 + 17'(count) || count < need) begin
                job.kind  = mbtre_pkg::KIND_BAD;
                job.cause = mbtre_pkg::CAUSE_SHORT;
              end else begin
                job.kind = mbtre_pkg::KIND_GOOD;
                if (pend_type == mbtre_pkg::DT_UINT16) begin
                  job.bits = {16'd0, w0};
                end else if (pend_type == mbtre_pkg::DT_INT16) begin
                  job.bits = {{16{w0[15]}}, w0};
                end else begin
                  job.bits = pend_order ? {w1, w0} : {w0, w1};
                end
              end
            end
          end
        end
        mbtre_pkg::REQ_TICK: begin
          if (waiting) begin
            elapsed_next = (elapsed != 16'hFFFF) ? elapsed + 16'd1 : elapsed;
            if (elapsed_next >= timeout) begin
              waiting_next = 1'b0;
              job_valid    = 1'b1;
              job.kind     = mbtre_pkg::KIND_BAD;
              job.tag      = pend_tag;
              job.vtype    = pend_type;
              job.cause    = mbtre_pkg::CAUSE_TIMEOUT;
            end
          end
        end
        mbtre_pkg::REQ_LINK: begin
          rx_pos_next = 17'd0;
          if (waiting) begin
            waiting_next = 1'b0;
            job_valid    = 1'b1;
            job.kind     = mbtre_pkg::KIND_BAD;
            job.tag      = pend_tag;
            job.vtype    = pend_type;
            job.cause    = mbtre_pkg::CAUSE_LINK;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout    <= mbtre_pkg::TIMEOUT_RESET;
      txn_ctr    <= 16'd0;
      waiting    <= 1'b0;
      pend_txn   <= 16'd0;
      pend_tag   <= '0;
      pend_type  <= 3'd0;
      pend_order <= 1'b0;
      elapsed    <= 16'd0;
      rx_pos     <= 17'd0;
      for (int i = 0; i < 9; i++) hdr[i] <= 8'd0;
      for (int i = 0; i < 4; i++) regs[i] <= 8'd0;
    end else begin
      if (cfg_we) timeout <= cfg_wdata;
      txn_ctr    <= txn_ctr_next;
      waiting    <= waiting_next;
      pend_txn   <= pend_txn_next;
      pend_tag   <= pend_tag_next;
      pend_type  <= pend_type_next;
      pend_order <= pend_order_next;
      elapsed    <= elapsed_next;
      rx_pos     <= rx_pos_next;
      hdr        <= hdr_next;
      regs       <= regs_next;
    end
  end

endmodule

// ===== hw/rtl/mbtre_jobq.sv =====
// Short job queue that decouples the front end from the back end.
// Depends on mbtre_pkg for the job type and depth.
module mbtre_jobq (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  mbtre_pkg::job_t wr_job,
  output logic            full,
  input  logic            rd_en,
  output mbtre_pkg::job_t rd_job,
  output logic            empty
);

  localparam int PtrBits = $clog2(mbtre_pkg::JOBQ_DEPTH);

  mbtre_pkg::job_t       mem [mbtre_pkg::JOBQ_DEPTH];
  logic [PtrBits-1:0]    wr_ptr, rd_ptr;
  logic [PtrBits:0]      fill;

  assign full   = (fill == (PtrBits + 1)'(mbtre_pkg::JOBQ_DEPTH));
  assign empty  = (fill == '0);
  assign rd_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en && !full) mem[wr_ptr] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en && !full) wr_ptr <= wr_ptr + PtrBits'(1);
      if (rd_en && !empty) rd_ptr <= rd_ptr + PtrBits'(1);
      fill <= fill + (PtrBits + 1)'(wr_en && !full) - (PtrBits + 1)'(rd_en && !empty);
    end
  end

endmodule

// ===== hw/rtl/mbtre_back.sv =====
// Back end: turns jobs into result transfers and holds the output register.
// Depends on mbtre_pkg and the shared assertion macro header.
`include "modbus_tcp_read_transaction_engine_defines.svh"

module mbtre_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  mbtre_pkg::job_t     q_job,
  output logic                q_pop,
  input  logic                pop,
  output logic                empty,
  output mbtre_pkg::result_t  result
);

  mbtre_pkg::back_state_t state, state_next;
  mbtre_pkg::job_t        cur;
  mbtre_pkg::result_t     out_q, out_d;
  logic                   out_valid;
  logic [3:0]             idx, idx_next;
  logic                   out_free;
  logic                   load;

  assign out_free = !out_valid || pop;
  assign empty    = !out_valid;
  assign result   = out_q;

  always_comb begin
    state_next = state;
    unique case (state)
      mbtre_pkg::BK_IDLE: begin
        if (out_free && !q_empty && q_job.kind == mbtre_pkg::KIND_TX) begin
          state_next = mbtre_pkg::BK_FRAME;
        end
      end
      mbtre_pkg::BK_FRAME: begin
        if (out_free && idx == mbtre_pkg::FRAME_LAST_IDX) state_next = mbtre_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    load     = 1'b0;
    idx_next = idx;
    out_d    = '0;
    unique case (state)
      mbtre_pkg::BK_IDLE: begin
        if (out_free && !q_empty) begin
          q_pop = 1'b1;
          load  = 1'b1;
          if (q_job.kind == mbtre_pkg::KIND_TX) begin
            out_d.out_kind = mbtre_pkg::KIND_TX;
            out_d.tx_byte  = mbtre_pkg::frame_byte(q_job, 4'd0);
            idx_next       = 4'd1;
          end else begin
            out_d.out_kind   = q_job.kind;
            out_d.result_tag = q_job.tag;
            out_d.value_bits = q_job.bits;
            out_d.value_type = q_job.vtype;
            out_d.fail_cause = q_job.cause;
          end
        end
      end
      mbtre_pkg::BK_FRAME: begin
        if (out_free) begin
          load             = 1'b1;
          out_d.out_kind   = mbtre_pkg::KIND_TX;
          out_d.tx_byte    = mbtre_pkg::frame_byte(cur, idx);
          out_d.frame_last = (idx == mbtre_pkg::FRAME_LAST_IDX);
          idx_next         = idx + 4'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_job;
    if (load) out_q <= out_d;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mbtre_pkg::BK_IDLE;
      idx       <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      out_valid <= load || (out_valid && !pop);
    end
  end

  `MBTRE_ASSERT_NEXT(a_last_byte_marked,
    state == mbtre_pkg::BK_FRAME && out_free && idx == mbtre_pkg::FRAME_LAST_IDX,
    out_valid && out_q.frame_last && out_q.out_kind == mbtre_pkg::KIND_TX,
    "final frame byte not marked")
  `MBTRE_ASSERT_NOW(a_idx_range, state == mbtre_pkg::BK_FRAME,
    idx != 4'd0 && idx <= mbtre_pkg::FRAME_LAST_IDX, "frame byte index out of range")
  `MBTRE_ASSERT_NOW(a_no_pop_in_frame, state == mbtre_pkg::BK_FRAME, !q_pop,
    "job queue popped while a frame is still being sent")

endmodule
